// ----- design/sv39ptw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sv39ptw_pkg;

  // Walk depth and derived widths
  localparam int unsigned LEVELS  = 3;
  localparam int unsigned LVL_W   = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int unsigned VA_BITS = 12 + 9 * LEVELS;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VPN_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // PTE bit positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W = 2;
  localparam int unsigned PTE_X = 3;
  localparam int unsigned PTE_U = 4;
  localparam int unsigned PTE_A = 6;
  localparam int unsigned PTE_D = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSLATE_ENABLE = 1'b0,
    CFG_ROOT_PPN         = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_PTE_READ  = 2'd1,
    OP_PTE_ACK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACC_FETCH = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_STORE = 2'd2
  } access_e;

  typedef enum logic [1:0] {
    K_READ  = 2'd0,
    K_WRITE = 2'd1,
    K_DONE  = 2'd2,
    K_FAULT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE             = 3'd0,
    CAUSE_FETCH_MISALIGNED = 3'd1,
    CAUSE_LOAD_MISALIGNED  = 3'd2,
    CAUSE_STORE_MISALIGNED = 3'd3,
    CAUSE_FETCH_PAGE_FAULT = 3'd4,
    CAUSE_LOAD_PAGE_FAULT  = 3'd5,
    CAUSE_STORE_PAGE_FAULT = 3'd6
  } cause_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] vaddr;
    logic [1:0]  access_kind;
    logic [1:0]  size_log2;
    logic        user_mode;
    logic [63:0] pte_value;
    logic        bus_error;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [63:0] pte_write_data;
    logic [2:0]  fault_cause;
  } out_item_t;

  typedef struct packed {
    phase_e             phase;
    logic [LVL_W-1:0]   walk_level;
    logic [VA_BITS-1:0] saved_vaddr;
    access_e            saved_access;
    logic               saved_user;
    logic [PA_W-1:0]    entry_address;
    logic [PA_W-1:0]    pending_phys;
  } walk_state_t;

  typedef struct packed {
    logic             translate_enable;
    logic [PPN_W-1:0] root_ppn;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/sv39ptw_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request and PTE response channel
interface sv39ptw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] vaddr;
  logic [1:0]  access_kind;
  logic [1:0]  size_log2;
  logic        user_mode;
  logic [63:0] pte_value;
  logic        bus_error;

  modport source (output valid, op, vaddr, access_kind, size_log2, user_mode,
                  pte_value, bus_error, input ready);
  modport sink   (input valid, op, vaddr, access_kind, size_log2, user_mode,
                  pte_value, bus_error, output ready);
endinterface

// Result channel
interface sv39ptw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] address;
  logic [63:0] pte_write_data;
  logic [2:0]  fault_cause;

  modport source (output valid, kind, address, pte_write_data, fault_cause, input ready);
  modport sink   (input valid, kind, address, pte_write_data, fault_cause, output ready);
endinterface

// Register write channel
interface sv39ptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/sv39_page_table_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Path: an input item is held in the input register, then the walk step writes
// its result into the result register, waiting while that register stays full.
// Throughput: one input item per cycle while the result register is free or
// draining; a page walk takes one PTE memory round trip per level visited, plus
// one for an accessed/dirty write-back when needed. Reset: asynchronous, clears
// the walk state, the configuration registers and the valid flags.
module sv39_page_table_walker (
  input  wire            clk_i,
  input  wire            rst_ni,
  sv39ptw_in_if.sink     in_i,
  sv39ptw_out_if.source  out_o,
  sv39ptw_cfg_if.sink    cfg_i
);
  import sv39ptw_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  in_item_t    in_item_d;
  logic        out_valid_q;
  out_item_t   out_item_q;
  walk_state_t state_q;
  walk_state_t state_d;
  cfg_t        cfg_q;
  logic        step_fire;
  logic        has_result;
  out_item_t   result;

  assign in_item_d = '{op:          in_i.op,
                       vaddr:       in_i.vaddr,
                       access_kind: in_i.access_kind,
                       size_log2:   in_i.size_log2,
                       user_mode:   in_i.user_mode,
                       pte_value:   in_i.pte_value,
                       bus_error:   in_i.bus_error};

  // Process the held item when the result register is free or draining
  assign step_fire  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_fire;
  assign cfg_i.ready = 1'b1;

  // Hold the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_item_d;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TRANSLATE_ENABLE: cfg_q.translate_enable <= cfg_i.data[0];
        CFG_ROOT_PPN:         cfg_q.root_ppn <= cfg_i.data[PPN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sv39ptw_step u_step (
    .item_i       (in_item_q),
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // Advance the walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Load the result register, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_item_q.kind;
  assign out_o.address        = out_item_q.address;
  assign out_o.pte_write_data = out_item_q.pte_write_data;
  assign out_o.fault_cause    = out_item_q.fault_cause;

endmodule

`default_nettype wire

// ----- design/sv39ptw_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_step (
  input  sv39ptw_pkg::in_item_t    item_i,
  input  sv39ptw_pkg::walk_state_t state_i,
  input  sv39ptw_pkg::cfg_t        cfg_i,
  output sv39ptw_pkg::walk_state_t state_o,
  output logic                     has_result_o,
  output sv39ptw_pkg::out_item_t   result_o
);
  import sv39ptw_pkg::*;

  // Fold the unused access code onto load
  function automatic access_e norm_access(input logic [1:0] a);
    access_e r;
    case (a)
      ACC_FETCH: r = ACC_FETCH;
      ACC_STORE: r = ACC_STORE;
      default:   r = ACC_LOAD;
    endcase
    return r;
  endfunction

  function automatic cause_e misaligned_cause(input access_e a);
    cause_e r;
    case (a)
      ACC_FETCH: r = CAUSE_FETCH_MISALIGNED;
      ACC_STORE: r = CAUSE_STORE_MISALIGNED;
      default:   r = CAUSE_LOAD_MISALIGNED;
    endcase
    return r;
  endfunction

  function automatic cause_e page_fault_cause(input access_e a);
    cause_e r;
    case (a)
      ACC_FETCH: r = CAUSE_FETCH_PAGE_FAULT;
      ACC_STORE: r = CAUSE_STORE_PAGE_FAULT;
      default:   r = CAUSE_LOAD_PAGE_FAULT;
    endcase
    return r;
  endfunction

  // VPN slice of the saved address for a given level
  function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_BITS-1:0] va,
                                              input logic [LVL_W-1:0] lvl);
    logic [VPN_W-1:0] r;
    r = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l)) r = va[12 + 9 * l +: VPN_W];
    end
    return r;
  endfunction

  access_e          acc_n;
  logic             misaligned;
  logic [PPN_W-1:0] ppn;
  logic [PPN_W-1:0] super_mask;
  logic [PA_W-1:0]  low_mask;
  logic [PA_W-1:0]  va_ext;
  logic [PA_W-1:0]  ppn_shift;
  logic [PA_W-1:0]  phys;
  logic [63:0]      pte;
  logic [63:0]      new_pte;
  logic [LVL_W-1:0] lvl_dn;
  logic             perm_ok;

  // Decode the request and the PTE
  always_comb begin
    acc_n = norm_access(item_i.access_kind);
    case (item_i.size_log2)
      2'd0:    misaligned = 1'b0;
      2'd1:    misaligned = item_i.vaddr[0];
      2'd2:    misaligned = |item_i.vaddr[1:0];
      default: misaligned = |item_i.vaddr[2:0];
    endcase

    pte       = item_i.pte_value;
    ppn       = pte[10 +: PPN_W];
    ppn_shift = {ppn, 12'b0};
    lvl_dn    = state_i.walk_level - LVL_W'(1);

    // Superpage and page-offset masks by level
    for (int i = 0; i < PPN_W; i++) begin
      super_mask[i] = (i < 9 * int'(state_i.walk_level));
    end
    for (int i = 0; i < PA_W; i++) begin
      low_mask[i] = (i < 12 + 9 * int'(state_i.walk_level));
      va_ext[i]   = (i < VA_BITS) ? state_i.saved_vaddr[i % VA_BITS] : 1'b0;
    end
    phys = (ppn_shift & ~low_mask) | (va_ext & low_mask);

    case (state_i.saved_access)
      ACC_FETCH: perm_ok = pte[PTE_X];
      ACC_STORE: perm_ok = pte[PTE_W];
      default:   perm_ok = pte[PTE_R];
    endcase

    new_pte = pte;
    new_pte[PTE_A] = 1'b1;
    if (state_i.saved_access == ACC_STORE) new_pte[PTE_D] = 1'b1;
  end

  // Advance the walk by one event
  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    result_o     = '0;
    case (item_i.op)
      OP_TRANSLATE: begin
        if (state_i.phase == PH_IDLE) begin
          has_result_o = 1'b1;
          if (misaligned) begin
            result_o.kind        = K_FAULT;
            result_o.address     = item_i.vaddr;
            result_o.fault_cause = misaligned_cause(acc_n);
          end else if (!cfg_i.translate_enable) begin
            result_o.kind    = K_DONE;
            result_o.address = item_i.vaddr;
          end else begin
            state_o.saved_vaddr   = item_i.vaddr[VA_BITS-1:0];
            state_o.saved_access  = acc_n;
            state_o.saved_user    = item_i.user_mode;
            state_o.walk_level    = LVL_W'(LEVELS - 1);
            state_o.entry_address = {cfg_i.root_ppn,
                                     item_i.vaddr[12 + 9 * (LEVELS - 1) +: VPN_W], 3'b0};
            state_o.phase         = PH_READ;
            result_o.kind         = K_READ;
            result_o.address      = 64'(state_o.entry_address);
          end
        end
      end
      OP_PTE_READ: begin
        if (state_i.phase == PH_READ) begin
          has_result_o = 1'b1;
          // Page fault unless one of the paths below overrides it
          state_o.phase        = PH_IDLE;
          result_o.kind        = K_FAULT;
          result_o.address     = 64'(state_i.saved_vaddr);
          result_o.fault_cause = page_fault_cause(state_i.saved_access);
          if (item_i.bus_error) begin
            result_o.address     = 64'(state_i.entry_address);
            result_o.fault_cause = CAUSE_LOAD_PAGE_FAULT;
          end else if (!pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
            // invalid or reserved entry: page fault
          end else if (!pte[PTE_R] && !pte[PTE_X]) begin
            // Pointer to the next table
            if (state_i.walk_level != '0) begin
              state_o.phase         = PH_READ;
              state_o.walk_level    = lvl_dn;
              state_o.entry_address = {ppn, vpn_of(state_i.saved_vaddr, lvl_dn), 3'b0};
              result_o              = '0;
              result_o.kind         = K_READ;
              result_o.address      = 64'(state_o.entry_address);
            end
          end else if (!perm_ok || (state_i.saved_user && !pte[PTE_U])) begin
            // permission fault
          end else if ((ppn & super_mask) != '0) begin
            // misaligned superpage
          end else if (new_pte != pte) begin
            state_o.pending_phys    = phys;
            state_o.phase           = PH_WRITE;
            result_o                = '0;
            result_o.kind           = K_WRITE;
            result_o.address        = 64'(state_i.entry_address);
            result_o.pte_write_data = new_pte;
          end else begin
            result_o         = '0;
            result_o.kind    = K_DONE;
            result_o.address = 64'(phys);
          end
        end
      end
      OP_PTE_ACK: begin
        if (state_i.phase == PH_WRITE) begin
          has_result_o  = 1'b1;
          state_o.phase = PH_IDLE;
          if (item_i.bus_error) begin
            result_o.kind        = K_FAULT;
            result_o.address     = 64'(state_i.entry_address);
            result_o.fault_cause = CAUSE_STORE_PAGE_FAULT;
          end else begin
            result_o.kind    = K_DONE;
            result_o.address = 64'(state_i.pending_phys);
          end
        end
      end
      default: begin
        // unknown operation: drop it
      end
    endcase
  end

endmodule

`default_nettype wire
